### design/i2cm_pkg.sv
// Shared types and constants for the I2C master register access block.
// Used by the sequencer and the top level; depends on nothing.

package i2cm_pkg;

  localparam int unsigned CfgIdxW = 4;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_ACK_TIMEOUT = 4'd0;
  localparam logic [CfgIdxW-1:0] REG_PHASE_TICKS = 4'd1;

  // Command opcodes carried with each tick.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [7:0] ABORT_DATA = 8'hFF;

  typedef enum logic [4:0] {
    ST_IDLE        = 5'd0,
    ST_W_START     = 5'd1,
    ST_W_TX_ADDR   = 5'd2,
    ST_W_ACK_ADDR  = 5'd3,
    ST_W_TX_REG    = 5'd4,
    ST_W_ACK_REG   = 5'd5,
    ST_W_TX_DATA   = 5'd6,
    ST_W_ACK_DATA  = 5'd7,
    ST_STOP        = 5'd8,
    ST_R_START     = 5'd9,
    ST_R_TX_ADDR   = 5'd10,
    ST_R_ACK_ADDR  = 5'd11,
    ST_R_TX_REG    = 5'd12,
    ST_R_ACK_REG   = 5'd13,
    ST_R_RESTART   = 5'd14,
    ST_R_TX_ADDRR  = 5'd15,
    ST_R_ACK_ADDRR = 5'd16,
    ST_R_RX        = 5'd17,
    ST_R_MACK      = 5'd18,
    ST_ABORT       = 5'd19
  } seq_state_e;

  typedef struct packed {
    logic [7:0]  ack_timeout;
    logic [15:0] phase_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [6:0] device_address;
    logic [7:0] register_address;
    logic [7:0] write_data;
    logic [7:0] burst_length;
    logic       sda_in;
  } tick_t;

  typedef struct packed {
    seq_state_e  state;
    logic [3:0]  bit_counter;
    logic [7:0]  shift_byte;
    logic [7:0]  bytes_left;
    logic [7:0]  ack_wait_count;
    logic [15:0] phase_count;
    logic [6:0]  held_device_address;
    logic [7:0]  held_register_address;
    logic [7:0]  held_write_data;
    logic        ack_failed;
  } seq_regs_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic [7:0] read_data;
    logic       read_valid;
    logic       last_byte;
    logic       done_res;
    logic       error;
    logic       busy_res;
  } result_t;

endpackage

### design/i2cm_seq.sv
// Bus sequencer of the I2C master: holds the command state and computes one tick.
// Depends on i2cm_pkg for the state encoding, the tick, config and result structs.

module i2cm_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  i2cm_pkg::tick_t  tick_i,
  input  i2cm_pkg::cfg_t   cfg_i,
  output i2cm_pkg::result_t res_o
);

  i2cm_pkg::seq_regs_t regs_q, regs_d;
  i2cm_pkg::seq_regs_t cur;
  i2cm_pkg::result_t   res;
  logic [15:0] lim;
  logic [16:0] pc_inc;
  logic [15:0] pc_next;
  logic        pend;
  logic        rd_cmd;
  logic        mack_ack;

  // Moves to a new state: clears the bit and phase counters and loads the
  // byte that the state shifts out. A read with no bytes left goes to stop.
  function automatic i2cm_pkg::seq_regs_t seq_enter(i2cm_pkg::seq_regs_t r,
                                                     i2cm_pkg::seq_state_e s);
    i2cm_pkg::seq_state_e t;
    t = s;
    if (t == i2cm_pkg::ST_R_RX && r.bytes_left == 8'd0) begin
      t = i2cm_pkg::ST_STOP;
    end
    r.state       = t;
    r.bit_counter = 4'd0;
    r.phase_count = 16'd0;
    unique case (t)
      i2cm_pkg::ST_W_TX_ADDR, i2cm_pkg::ST_R_TX_ADDR: begin
        r.shift_byte = {r.held_device_address, 1'b0};
      end
      i2cm_pkg::ST_W_TX_REG, i2cm_pkg::ST_R_TX_REG: begin
        r.shift_byte = r.held_register_address;
      end
      i2cm_pkg::ST_W_TX_DATA: begin
        r.shift_byte = r.held_write_data;
      end
      i2cm_pkg::ST_R_TX_ADDRR: begin
        r.shift_byte = {r.held_device_address, 1'b1};
      end
      i2cm_pkg::ST_R_RX: begin
        r.shift_byte = 8'd0;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic i2cm_pkg::seq_state_e seq_succ(i2cm_pkg::seq_state_e s);
    return i2cm_pkg::seq_state_e'(5'(s + 5'd1));
  endfunction

  always_comb begin
    cur          = regs_q;
    res          = '0;
    res.scl_out  = 1'b1;
    res.sda_out  = 1'b1;
    res.busy_res = 1'b1;

    // An idle sequencer takes a new command on this same tick.
    if (cur.state == i2cm_pkg::ST_IDLE || cur.state > i2cm_pkg::ST_ABORT) begin
      cur.state = i2cm_pkg::ST_IDLE;
      if (tick_i.opcode == i2cm_pkg::OP_WRITE || tick_i.opcode == i2cm_pkg::OP_READ) begin
        cur.held_device_address   = tick_i.device_address;
        cur.held_register_address = tick_i.register_address;
        cur.held_write_data       = tick_i.write_data;
        cur.bytes_left            = (tick_i.opcode == i2cm_pkg::OP_READ) ?
                                    tick_i.burst_length : 8'd0;
        cur.ack_failed            = 1'b0;
        cur = seq_enter(cur, (tick_i.opcode == i2cm_pkg::OP_WRITE) ?
                             i2cm_pkg::ST_W_START : i2cm_pkg::ST_R_START);
      end else begin
        res.busy_res = 1'b0;
      end
    end

    lim      = (cfg_i.phase_ticks == 16'd0) ? 16'd1 : cfg_i.phase_ticks;
    pc_inc   = {1'b0, cur.phase_count} + 17'd1;
    pend     = (pc_inc >= {1'b0, lim});
    pc_next  = pend ? 16'd0 : pc_inc[15:0];
    rd_cmd   = (cur.state >= i2cm_pkg::ST_R_START);
    mack_ack = (cur.bytes_left > 8'd1);
    regs_d   = cur;

    unique case (cur.state)
      i2cm_pkg::ST_IDLE: begin
      end
      i2cm_pkg::ST_W_START, i2cm_pkg::ST_R_START, i2cm_pkg::ST_R_RESTART: begin
        res.scl_out        = (cur.bit_counter < 4'd2);
        res.sda_out        = (cur.bit_counter == 4'd0);
        regs_d.phase_count = pc_next;
        if (pend) begin
          if (cur.bit_counter >= 4'd2) begin
            regs_d = seq_enter(regs_d, seq_succ(cur.state));
          end else begin
            regs_d.bit_counter = cur.bit_counter + 4'd1;
          end
        end
      end
      i2cm_pkg::ST_W_TX_ADDR, i2cm_pkg::ST_W_TX_REG, i2cm_pkg::ST_W_TX_DATA,
      i2cm_pkg::ST_R_TX_ADDR, i2cm_pkg::ST_R_TX_REG, i2cm_pkg::ST_R_TX_ADDRR: begin
        res.scl_out        = cur.bit_counter[0];
        res.sda_out        = cur.shift_byte[7];
        regs_d.phase_count = pc_next;
        if (pend) begin
          if (cur.bit_counter[0]) begin
            regs_d.shift_byte = {cur.shift_byte[6:0], 1'b0};
          end
          if (cur.bit_counter == 4'd15) begin
            regs_d = seq_enter(regs_d, seq_succ(cur.state));
          end else begin
            regs_d.bit_counter = cur.bit_counter + 4'd1;
          end
        end
      end
      i2cm_pkg::ST_W_ACK_ADDR, i2cm_pkg::ST_W_ACK_REG, i2cm_pkg::ST_W_ACK_DATA,
      i2cm_pkg::ST_R_ACK_ADDR, i2cm_pkg::ST_R_ACK_REG, i2cm_pkg::ST_R_ACK_ADDRR: begin
        unique case (cur.bit_counter)
          4'd0: begin
            res.scl_out        = 1'b0;
            regs_d.phase_count = pc_next;
            if (pend) regs_d.bit_counter = 4'd1;
          end
          4'd1: begin
            regs_d.phase_count = pc_next;
            if (pend) begin
              regs_d.bit_counter    = 4'd2;
              regs_d.ack_wait_count = 8'd0;
            end
          end
          4'd2: begin
            // SCL is held high while SDA is sampled for the acknowledge.
            if (!tick_i.sda_in) begin
              regs_d.bit_counter = 4'd3;
              regs_d.phase_count = 16'd0;
            end else if (cur.ack_wait_count >= cfg_i.ack_timeout) begin
              regs_d.ack_failed = 1'b1;
              if (rd_cmd) begin
                regs_d = seq_enter(regs_d, i2cm_pkg::ST_ABORT);
              end else begin
                regs_d.bit_counter = 4'd4;
                regs_d.phase_count = 16'd0;
              end
            end else begin
              regs_d.ack_wait_count = cur.ack_wait_count + 8'd1;
            end
          end
          4'd4: begin
            res.scl_out        = 1'b0;
            res.sda_out        = 1'b0;
            regs_d.phase_count = pc_next;
            if (pend) regs_d.bit_counter = 4'd5;
          end
          4'd5: begin
            res.sda_out        = 1'b0;
            regs_d.phase_count = pc_next;
            if (pend) regs_d.bit_counter = 4'd6;
          end
          4'd6: begin
            regs_d.phase_count = pc_next;
            if (pend) regs_d.bit_counter = 4'd3;
          end
          default: begin
            res.scl_out        = 1'b0;
            regs_d.phase_count = pc_next;
            if (pend) regs_d = seq_enter(regs_d, seq_succ(cur.state));
          end
        endcase
      end
      i2cm_pkg::ST_R_RX: begin
        res.scl_out        = ~cur.bit_counter[0];
        regs_d.phase_count = pc_next;
        if (pend) begin
          if (!cur.bit_counter[0]) begin
            regs_d.shift_byte = {cur.shift_byte[6:0], tick_i.sda_in};
            if (cur.bit_counter == 4'd14) begin
              res.read_valid = 1'b1;
              res.read_data  = regs_d.shift_byte;
              res.last_byte  = (cur.bytes_left == 8'd1);
            end
          end
          if (cur.bit_counter == 4'd15) begin
            regs_d = seq_enter(regs_d, i2cm_pkg::ST_R_MACK);
          end else begin
            regs_d.bit_counter = cur.bit_counter + 4'd1;
          end
        end
      end
      i2cm_pkg::ST_R_MACK: begin
        res.scl_out        = (cur.bit_counter == 4'd1);
        res.sda_out        = mack_ack ? (cur.bit_counter >= 4'd3) : 1'b1;
        regs_d.phase_count = pc_next;
        if (pend) begin
          if (cur.bit_counter >= (mack_ack ? 4'd3 : 4'd2)) begin
            if (cur.bytes_left != 8'd0) begin
              regs_d.bytes_left = cur.bytes_left - 8'd1;
            end
            regs_d = seq_enter(regs_d, i2cm_pkg::ST_R_RX);
          end else begin
            regs_d.bit_counter = cur.bit_counter + 4'd1;
          end
        end
      end
      i2cm_pkg::ST_STOP, i2cm_pkg::ST_ABORT: begin
        res.scl_out        = (cur.bit_counter >= 4'd1);
        res.sda_out        = (cur.bit_counter >= 4'd2);
        regs_d.phase_count = pc_next;
        if (pend) begin
          if (cur.bit_counter >= 4'd2) begin
            res.done_res = 1'b1;
            if (cur.state == i2cm_pkg::ST_ABORT) res.read_data = i2cm_pkg::ABORT_DATA;
            regs_d.state       = i2cm_pkg::ST_IDLE;
            regs_d.bit_counter = 4'd0;
            regs_d.phase_count = 16'd0;
          end else begin
            regs_d.bit_counter = cur.bit_counter + 4'd1;
          end
        end
      end
      default: begin
      end
    endcase

    res.error = regs_d.ack_failed;
  end

  assign res_o = res;

  // The all-zero pattern is the idle state with cleared counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= '0;
    end else if (step_i) begin
      regs_q <= regs_d;
    end
  end

endmodule

### design/i2c_master_register_access_top.sv
// Top level of the I2C master register access block: config registers,
// sequencer instance and the output register with its skid stage.
// Depends on i2cm_pkg and i2cm_seq.

// Each accepted item is one bus tick and yields exactly one result item with
// the SCL and SDA levels for that tick, plus read data and status. The block
// takes one item per clock while in_stall_o is low: the sequencer advances
// its state in the cycle an item is accepted, and the result is registered
// in the output register or, while that one is held, in the skid register
// behind it; thus one more item fits and in_stall_o is a registered signal.
// Configuration registers (ack_timeout at index 0, phase_ticks at index 1)
// are always ready and must be written only while the block is idle.
module i2c_master_register_access_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    opcode_i,
  input  logic [6:0]                    device_address_i,
  input  logic [7:0]                    register_address_i,
  input  logic [7:0]                    write_data_i,
  input  logic [7:0]                    burst_length_i,
  input  logic                          sda_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          scl_out_o,
  output logic                          sda_out_o,
  output logic [7:0]                    read_data_o,
  output logic                          read_valid_o,
  output logic                          last_byte_o,
  output logic                          done_res_o,
  output logic                          error_o,
  output logic                          busy_res_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [i2cm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [15:0]                   cfg_data_i
);

  i2cm_pkg::cfg_t    cfg_q;
  i2cm_pkg::tick_t   tick;
  i2cm_pkg::result_t step_res;
  i2cm_pkg::result_t out_q, skid_q;
  logic              out_valid_q, skid_valid_q;
  logic              in_fire, out_fire;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ack_timeout <= 8'd250;
      cfg_q.phase_ticks <= 16'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == i2cm_pkg::REG_ACK_TIMEOUT) begin
        cfg_q.ack_timeout <= cfg_data_i[7:0];
      end else if (cfg_index_i == i2cm_pkg::REG_PHASE_TICKS) begin
        cfg_q.phase_ticks <= cfg_data_i;
      end
    end
  end

  assign tick.opcode           = opcode_i;
  assign tick.device_address   = device_address_i;
  assign tick.register_address = register_address_i;
  assign tick.write_data       = write_data_i;
  assign tick.burst_length     = burst_length_i;
  assign tick.sda_in           = sda_in_i;

  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i && !skid_valid_q;
  assign out_fire   = out_valid_q && !out_stall_i;

  i2cm_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_fire),
    .tick_i (tick),
    .cfg_i  (cfg_q),
    .res_o  (step_res)
  );

  // The skid register only fills while the output register is full and held.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_fire || !out_valid_q) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= in_fire;
        end
      end else if (in_fire) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire || !out_valid_q) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_fire) begin
        out_q <= step_res;
      end
    end else if (in_fire) begin
      skid_q <= step_res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign scl_out_o    = out_q.scl_out;
  assign sda_out_o    = out_q.sda_out;
  assign read_data_o  = out_q.read_data;
  assign read_valid_o = out_q.read_valid;
  assign last_byte_o  = out_q.last_byte;
  assign done_res_o   = out_q.done_res;
  assign error_o      = out_q.error;
  assign busy_res_o   = out_q.busy_res;

endmodule

### design/i2cm_checker.sv
// Port-level checker for the I2C master register access block, bound to the top.
// Depends only on the top level's ports.

module i2cm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       scl_out_o,
  input logic       sda_out_o,
  input logic       read_valid_o,
  input logic       last_byte_o,
  input logic       done_res_o,
  input logic       busy_res_o
);

  // A held result item stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  // A command ends on a stop, which leaves the bus released.
  a_done_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> busy_res_o && scl_out_o && sda_out_o)
    else $error("command finished without a released bus");

  // With no command in progress the bus is idle.
  a_idle_bus: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !busy_res_o |-> scl_out_o && sda_out_o && !done_res_o && !read_valid_o)
    else $error("bus activity outside a command");

  // A received byte is sampled at the end of an SCL high phase.
  a_read_scl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && read_valid_o |-> busy_res_o && scl_out_o && sda_out_o && !done_res_o)
    else $error("read byte reported outside a receive phase");

  a_last_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_byte_o |-> read_valid_o)
    else $error("last byte flagged without read data");

endmodule

bind i2c_master_register_access_top i2cm_checker u_i2cm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .scl_out_o    (scl_out_o),
  .sda_out_o    (sda_out_o),
  .read_valid_o (read_valid_o),
  .last_byte_o  (last_byte_o),
  .done_res_o   (done_res_o),
  .busy_res_o   (busy_res_o)
);
